// File: src/wfm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wfm_pkg
// Shared constants, types and table builders for the windowed fsk modulator.
// ---------------------------------------------------------------------------
package wfm_pkg;

    localparam int SINE_DEPTH = 1024;
    localparam int SINE_AW    = 10;
    localparam int PHASE_W    = 32;
    localparam int TWO_DEPTH  = 2 * SINE_DEPTH;

    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    // register indexes, byte address is 4 times the index
    localparam logic [2:0] REG_PREAMBLE  = 3'd0;
    localparam logic [2:0] REG_PAYLOAD   = 3'd1;
    localparam logic [2:0] REG_SPS       = 3'd2;
    localparam logic [2:0] REG_TONE_ZERO = 3'd3;
    localparam logic [2:0] REG_TONE_ONE  = 3'd4;
    localparam logic [2:0] REG_WIN_STEP  = 3'd5;
    localparam logic [2:0] REG_GAIN      = 3'd6;
    localparam logic [2:0] REG_SEED      = 3'd7;

    localparam logic [7:0]  RST_PREAMBLE  = 8'd32;
    localparam logic [15:0] RST_PAYLOAD   = 16'd1024;
    localparam logic [15:0] RST_SPS       = 16'd2205;
    localparam logic [31:0] RST_TONE_ZERO = 32'd116868084;
    localparam logic [31:0] RST_TONE_ONE  = 32'd214258154;
    localparam logic [31:0] RST_WIN_STEP  = 32'd1948702;
    localparam logic [14:0] RST_GAIN      = 15'd29491;
    localparam logic [15:0] RST_SEED      = 16'hACE1;

    // sequencer step codes
    localparam logic [2:0] STEP_WAIT = 3'd0;
    localparam logic [2:0] STEP_READ = 3'd1;
    localparam logic [2:0] STEP_MUL1 = 3'd2;
    localparam logic [2:0] STEP_MUL2 = 3'd3;
    localparam logic [2:0] STEP_OUT  = 3'd4;

    typedef enum logic [1:0] {
        JMP_ALWAYS = 2'd0,
        JMP_ON_REQ = 2'd1,
        JMP_OUT    = 2'd2
    } t_jump;

    typedef struct packed {
        logic       take_in;
        logic       rom_rd;
        logic       mul_en;
        logic       mul_sel;
        logic       commit;
        t_jump      jump;
        logic [2:0] next;
        logic [2:0] alt;
    } t_ucode;

    typedef logic signed [15:0] t_sine_rom [SINE_DEPTH];

    function automatic t_ucode ucode_word(input logic [2:0] step);
        t_ucode w;
        w = '{take_in: 1'b0, rom_rd: 1'b0, mul_en: 1'b0, mul_sel: 1'b0, commit: 1'b0,
              jump: JMP_ALWAYS, next: STEP_WAIT, alt: STEP_WAIT};
        case (step)
            STEP_WAIT: begin
                w.take_in = 1'b1;
                w.jump    = JMP_ON_REQ;
                w.next    = STEP_READ;
                w.alt     = STEP_WAIT;
            end
            STEP_READ: begin
                w.rom_rd = 1'b1;
                w.next   = STEP_MUL1;
            end
            STEP_MUL1: begin
                w.mul_en = 1'b1;
                w.next   = STEP_MUL2;
            end
            STEP_MUL2: begin
                w.mul_en  = 1'b1;
                w.mul_sel = 1'b1;
                w.next    = STEP_OUT;
            end
            STEP_OUT: begin
                // waits while the result register is full and the output is stalled, may take the next request
                w.take_in = 1'b1;
                w.commit  = 1'b1;
                w.jump    = JMP_OUT;
                w.next    = STEP_READ;
                w.alt     = STEP_WAIT;
            end
            default: begin
                w.next = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

    function automatic logic [15:0] lfsr_step(input logic [15:0] v);
        return (v >> 1) ^ (v[0] ? LFSR_TAPS : 16'h0000);
    endfunction

    // sin(m/N * pi/2) in Q15, taylor series on magnitudes in Q30
    function automatic logic [15:0] quarter_sine(input longint unsigned m);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned v;
        x    = (m * PI_Q30 + longint'(SINE_DEPTH)) / TWO_DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
        term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
        term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
        term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
        term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
        term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
        term = ((term * x2) >> 30) / 64'd210; sum = sum - term;
        term = ((term * x2) >> 30) / 64'd272; sum = sum + term;
        v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[15:0];
    endfunction

    function automatic t_sine_rom build_sine_rom();
        t_sine_rom       rom;
        longint unsigned r;
        longint unsigned q;
        longint unsigned rem;
        longint unsigned m;
        logic [15:0]     s;
        for (int i = 0; i < SINE_DEPTH; i++) begin
            r   = 64'(4 * i);
            q   = r >> SINE_AW;
            rem = r & longint'(SINE_DEPTH - 1);
            m   = q[0] ? longint'(SINE_DEPTH) - rem : rem;
            s   = quarter_sine(m);
            rom[i] = (q >= 64'd2) ? -$signed(s) : $signed(s);
        end
        return rom;
    endfunction

endpackage

// File: src/windowed_fsk_modulator.sv
`timescale 1ns / 1ps
// sequencer program per request: table read, two passes through the shared
//   multiplier and an output step; the next request can be taken in the
//   output step, which holds while the result register is full and stalled
// reset: synchronous active low; configuration registers take their default
//   values and a new frame starts with the default seed
// ---------------------------------------------------------------------------
// windowed_fsk_modulator
// Binary fsk frame generator: preamble, lfsr payload, hann windowed tones.
// A microcoded sequencer drives a datapath with one multiplier.
// ---------------------------------------------------------------------------
module windowed_fsk_modulator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_restart,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_sample,
    output logic               o_symbol_bit,
    output logic               o_frame_last,
    output logic               o_frame_done,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW = wfm_pkg::SINE_AW;
    localparam int PW = wfm_pkg::PHASE_W;

    // configuration registers
    logic [7:0]  r_preamble;
    logic [15:0] r_payload;
    logic [15:0] r_sps;
    logic [31:0] r_tone_zero;
    logic [31:0] r_tone_one;
    logic [31:0] r_win_step;
    logic [14:0] r_gain;
    logic [15:0] r_seed;

    // frame state
    logic [15:0]   r_prbs,   n_prbs;
    logic [16:0]   r_bc,     n_bc;
    logic [15:0]   r_sc,     n_sc;
    logic [PW-1:0] r_ph0,    n_ph0;
    logic [PW-1:0] r_ph1,    n_ph1;
    logic [PW-1:0] r_wph,    n_wph;
    logic          r_bit,    n_bit;
    logic          r_finished, n_finished;

    // sequencer and datapath
    logic [2:0]        r_step, n_step;
    wfm_pkg::t_ucode   cw;
    logic [45:0]       r_prod;
    logic              r_out_valid;
    logic signed [15:0] r_sample;
    logic              r_symbol_bit;
    logic              r_frame_last;
    logic              r_frame_done;

    logic               cfg_wr;
    logic               in_acc;
    logic               can_out;
    logic               commit_fire;
    logic [AW-1:0]      tone_addr;
    logic [PW-1:0]      cos_phase;
    logic signed [15:0] rom_tone;
    logic signed [15:0] rom_cos;
    logic [15:0]        tone_neg;
    logic [14:0]        tmag;
    logic [16:0]        w_full;
    logic [15:0]        w_val;
    logic [29:0]        mul_a;
    logic [15:0]        mul_b;
    logic [46:0]        rnd_sum;
    logic [15:0]        rnd_mag;
    logic [15:0]        sat_mag;
    logic [16:0]        total_bits;
    logic               sym_end;
    logic               frm_end;
    logic [16:0]        bc_inc;
    logic [15:0]        prbs_next;
    logic [15:0]        seed_next;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preamble  <= wfm_pkg::RST_PREAMBLE;
            r_payload   <= wfm_pkg::RST_PAYLOAD;
            r_sps       <= wfm_pkg::RST_SPS;
            r_tone_zero <= wfm_pkg::RST_TONE_ZERO;
            r_tone_one  <= wfm_pkg::RST_TONE_ONE;
            r_win_step  <= wfm_pkg::RST_WIN_STEP;
            r_gain      <= wfm_pkg::RST_GAIN;
            r_seed      <= wfm_pkg::RST_SEED;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                wfm_pkg::REG_PREAMBLE:  r_preamble  <= pwdata[7:0];
                wfm_pkg::REG_PAYLOAD:   r_payload   <= pwdata[15:0];
                wfm_pkg::REG_SPS:       r_sps       <= pwdata[15:0];
                wfm_pkg::REG_TONE_ZERO: r_tone_zero <= pwdata;
                wfm_pkg::REG_TONE_ONE:  r_tone_one  <= pwdata;
                wfm_pkg::REG_WIN_STEP:  r_win_step  <= pwdata;
                wfm_pkg::REG_GAIN:      r_gain      <= pwdata[14:0];
                wfm_pkg::REG_SEED:      r_seed      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            wfm_pkg::REG_PREAMBLE:  prdata = {24'd0, r_preamble};
            wfm_pkg::REG_PAYLOAD:   prdata = {16'd0, r_payload};
            wfm_pkg::REG_SPS:       prdata = {16'd0, r_sps};
            wfm_pkg::REG_TONE_ZERO: prdata = r_tone_zero;
            wfm_pkg::REG_TONE_ONE:  prdata = r_tone_one;
            wfm_pkg::REG_WIN_STEP:  prdata = r_win_step;
            wfm_pkg::REG_GAIN:      prdata = {17'd0, r_gain};
            wfm_pkg::REG_SEED:      prdata = {16'd0, r_seed};
            default:                prdata = 32'd0;
        endcase
    end

    // ---------------- sequencer ----------------
    assign cw          = wfm_pkg::ucode_word(r_step);
    assign can_out     = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !(cw.take_in && (!cw.commit || can_out));
    assign in_acc      = i_in_valid && !o_in_stall;
    assign commit_fire = cw.commit && can_out;

    always_comb begin
        case (cw.jump)
            wfm_pkg::JMP_ALWAYS: n_step = cw.next;
            wfm_pkg::JMP_ON_REQ: n_step = in_acc ? cw.next : cw.alt;
            wfm_pkg::JMP_OUT: begin
                if (!can_out) begin
                    n_step = r_step;
                end else begin
                    n_step = in_acc ? cw.next : cw.alt;
                end
            end
            default:             n_step = wfm_pkg::STEP_WAIT;
        endcase
    end

    // ---------------- table lookups ----------------
    assign tone_addr = r_bit ? r_ph1[PW-1 -: AW] : r_ph0[PW-1 -: AW];
    // cosine is the sine a quarter turn ahead
    assign cos_phase = r_wph + (PW'(1) << (PW - 2));

    wfm_sine_rom u_rom (
        .i_clk    (i_clk),
        .i_rd_en  (cw.rom_rd),
        .i_addr_a (tone_addr),
        .i_addr_b (cos_phase[PW-1 -: AW]),
        .o_data_a (rom_tone),
        .o_data_b (rom_cos)
    );

    // ---------------- shared multiplier ----------------
    assign tone_neg = -rom_tone;
    assign tmag     = rom_tone[15] ? tone_neg[14:0] : rom_tone[14:0];
    assign w_full   = 17'sd32767 - {rom_cos[15], rom_cos};
    assign w_val    = w_full[15:0];
    assign mul_a    = cw.mul_sel ? r_prod[29:0] : {15'd0, tmag};
    assign mul_b    = cw.mul_sel ? w_val : {1'b0, r_gain};

    always_ff @(posedge i_clk) begin
        if (cw.mul_en) begin
            r_prod <= 46'(mul_a) * 46'(mul_b);
        end
    end

    // round half away on the magnitude, then saturate
    assign rnd_sum = {1'b0, r_prod} + (47'd1 << 30);
    assign rnd_mag = rnd_sum[46:31];
    assign sat_mag = (rnd_mag > 16'd32767) ? 16'd32767 : rnd_mag;

    // ---------------- frame control ----------------
    assign total_bits = {9'd0, r_preamble} + {1'b0, r_payload};
    assign sym_end    = ({1'b0, r_sc} + 17'd1) >= {1'b0, r_sps};
    assign frm_end    = sym_end && (({1'b0, r_bc} + 18'd1) >= {1'b0, total_bits});
    assign bc_inc     = r_bc + 17'd1;
    assign prbs_next  = wfm_pkg::lfsr_step(r_prbs);
    assign seed_next  = wfm_pkg::lfsr_step(r_seed);

    always_comb begin
        n_prbs     = r_prbs;
        n_bc       = r_bc;
        n_sc       = r_sc;
        n_ph0      = r_ph0;
        n_ph1      = r_ph1;
        n_wph      = r_wph;
        n_bit      = r_bit;
        n_finished = r_finished;
        if (commit_fire && !r_finished) begin
            n_ph0 = r_ph0 + r_tone_zero[PW-1:0];
            n_ph1 = r_ph1 + r_tone_one[PW-1:0];
            n_wph = r_wph + r_win_step[PW-1:0];
            if (!sym_end) begin
                n_sc = r_sc + 16'd1;
            end else begin
                n_sc  = 16'd0;
                n_wph = '0;
                if (frm_end) begin
                    n_finished = 1'b1;
                end else begin
                    n_bc = bc_inc;
                    if (bc_inc < {9'd0, r_preamble}) begin
                        n_bit = ~bc_inc[0];
                    end else begin
                        n_prbs = prbs_next;
                        n_bit  = prbs_next[0];
                    end
                end
            end
        end
        // a restart overrides whatever the finishing request left behind
        if (in_acc && i_restart) begin
            n_bc       = 17'd0;
            n_sc       = 16'd0;
            n_ph0      = '0;
            n_ph1      = '0;
            n_wph      = '0;
            n_prbs     = r_seed;
            n_finished = 1'b0;
            if (total_bits == 17'd0) begin
                n_finished = 1'b1;
                n_bit      = 1'b0;
            end else if (r_preamble != 8'd0) begin
                n_bit = 1'b1;
            end else begin
                n_prbs = seed_next;
                n_bit  = seed_next[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= wfm_pkg::STEP_WAIT;
            r_prbs     <= wfm_pkg::RST_SEED;
            r_bc       <= 17'd0;
            r_sc       <= 16'd0;
            r_ph0      <= '0;
            r_ph1      <= '0;
            r_wph      <= '0;
            r_bit      <= 1'b1;
            r_finished <= 1'b0;
        end else begin
            r_step     <= n_step;
            r_prbs     <= n_prbs;
            r_bc       <= n_bc;
            r_sc       <= n_sc;
            r_ph0      <= n_ph0;
            r_ph1      <= n_ph1;
            r_wph      <= n_wph;
            r_bit      <= n_bit;
            r_finished <= n_finished;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit_fire) begin
            if (r_finished) begin
                r_sample     <= 16'sd0;
                r_symbol_bit <= 1'b0;
                r_frame_last <= 1'b0;
                r_frame_done <= 1'b1;
            end else begin
                r_sample     <= rom_tone[15] ? -$signed(sat_mag) : $signed(sat_mag);
                r_symbol_bit <= r_bit;
                r_frame_last <= frm_end;
                r_frame_done <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample     = r_sample;
    assign o_symbol_bit = r_symbol_bit;
    assign o_frame_last = r_frame_last;
    assign o_frame_done = r_frame_done;

endmodule

// File: src/wfm_sine_rom.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wfm_sine_rom
// Q15 sine table with two registered read ports, tone and window lookups.
// ---------------------------------------------------------------------------
module wfm_sine_rom (
    input  logic                              i_clk,
    input  logic                              i_rd_en,
    input  logic [wfm_pkg::SINE_AW-1:0]       i_addr_a,
    input  logic [wfm_pkg::SINE_AW-1:0]       i_addr_b,
    output logic signed [15:0]                o_data_a,
    output logic signed [15:0]                o_data_b
);

    localparam wfm_pkg::t_sine_rom SINE_ROM = wfm_pkg::build_sine_rom();

    logic signed [15:0] r_data_a;
    logic signed [15:0] r_data_b;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_data_a <= SINE_ROM[i_addr_a];
            r_data_b <= SINE_ROM[i_addr_b];
        end
    end

    assign o_data_a = r_data_a;
    assign o_data_b = r_data_b;

endmodule
